// ===== hdl/btalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// btalloc_pkg
// Shared types and constants for the boundary-tag best-fit allocator.
// ----------------------------------------------------------------------------
package btalloc_pkg;

	localparam int HEAP_BYTES_DEF = 16384;
	localparam int INIT_CHUNK_DEF = 256;
	// byte offsets carry headroom so that sums and wrapped differences stay visible
	localparam int OW = 34;
	localparam int TW = 32;
	localparam logic [TW-1:0] SIZE_MASK = 32'hFFFF_FFF8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ACCEPT,
		CMD_WALK_RD,
		CMD_WALK,
		CMD_BEST_RD,
		CMD_LAST_RD,
		CMD_EXT,
		CMD_GROW_H,
		CMD_GROW_F,
		CMD_GROW_E,
		CMD_FREE_RD,
		CMD_FREE_HDR,
		CMD_FREE_FTR,
		CMD_M_PF,
		CMD_M_PH,
		CMD_M_NH,
		CMD_M_SUM,
		CMD_M_WH,
		CMD_M_WF,
		CMD_CARVE_RD,
		CMD_CARVE_H,
		CMD_CARVE_F,
		CMD_CARVE_RH,
		CMD_CARVE_RF,
		CMD_PUSH
	} dp_cmd_t;

	typedef struct packed {
		logic op;
		logic zero_req;
		logic free_bad;
		logic hdr_bad;
		logic walk_stop;
		logic found;
		logic oom;
		logic both_alloc;
		logic split;
		logic clr_last;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_CHK,
		S_WALK,
		S_W_END,
		S_EXT,
		S_G_H,
		S_G_F,
		S_G_E,
		S_F_HDR,
		S_F_FTR,
		S_M_PF,
		S_M_PH,
		S_M_NH,
		S_M_SUM,
		S_M_WH,
		S_M_WF,
		S_C_RD,
		S_C_H,
		S_C_F,
		S_C_RH,
		S_C_RF,
		S_OUT
	} state_t;

endpackage

// ===== hdl/btalloc_dp.sv =====
// ----------------------------------------------------------------------------
// btalloc_dp
// Heap word memory, block pointers and tag arithmetic, driven by commands.
// ----------------------------------------------------------------------------
module btalloc_dp #(
	parameter int HEAP_BYTES       = btalloc_pkg::HEAP_BYTES_DEF,
	parameter int INIT_CHUNK_BYTES = btalloc_pkg::INIT_CHUNK_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  btalloc_pkg::dp_cmd_t   cmd,
	input  logic                   in_op,
	input  logic [14:0]            in_request_bytes,
	input  logic [13:0]            in_block_address,
	output btalloc_pkg::dp_status_t st,
	output logic [13:0]            out_payload_address,
	output logic [1:0]             out_status
);
	import btalloc_pkg::*;

	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int IW    = $clog2(DEPTH);
	localparam int CHUNK = ((INIT_CHUNK_BYTES / 4 + 1) / 2) * 8;
	localparam int FTR_W = (8 + CHUNK) / 4;
	localparam int EPI_W = (12 + CHUNK) / 4;

	logic [TW-1:0] mem [DEPTH];
	logic [TW-1:0] rd_q;
	logic          rd_oob_q;
	logic [TW-1:0] rd;
	logic          rd_en, wr_en, rd_ok, wr_ok;
	logic [OW-1:0] rd_off, wr_off;
	logic [TW-1:0] wr_data;

	logic [IW-1:0] clr_q;
	logic [OW-1:0] brk_q, bp_q, best_q, last_q, pbp_q;
	logic [TW-1:0] sz_q, bestsz_q, psz_q, total_q, fsize_q;
	logic [15:0]   asize_q, ext_q;
	logic          found_q, pal_q, op_q;
	logic [14:0]   req_q;
	logic [13:0]   addr_q, res_addr_q, out_addr_q;
	logic [1:0]    status_q, out_status_q;

	// combinational helpers
	logic [TW-1:0] csz, asize32, rest;
	logic [OW-1:0] nxt;
	logic          hit, upd, endw;
	logic [15:0]   ext_c;
	logic [15:0]   r16;
	logic [TW-1:0] init_val;

	assign rd = rd_oob_q ? TW'(1) : rd_q;
	assign csz = rd & SIZE_MASK;
	assign asize32 = TW'(asize_q);
	assign rest = fsize_q - asize32;
	assign nxt = bp_q + OW'(csz);
	assign hit = !rd[0] && csz == asize32;
	assign upd = !rd[0] && asize32 < csz && (!found_q || csz < bestsz_q);
	assign endw = csz == '0 || nxt > brk_q;
	assign ext_c = (!rd[0] && csz < asize32) ? asize_q - csz[15:0] : asize_q;
	assign r16 = {1'b0, in_request_bytes} + 16'd15;

	always_comb begin
		if (clr_q == IW'(1) || clr_q == IW'(2))
			init_val = TW'(9);
		else if (clr_q == IW'(3) || clr_q == IW'(FTR_W))
			init_val = TW'(CHUNK);
		else if (clr_q == IW'(EPI_W))
			init_val = TW'(1);
		else
			init_val = '0;
	end

	assign st.op         = op_q;
	assign st.zero_req   = req_q == '0;
	assign st.free_bad   = addr_q[2:0] != 3'd0 || addr_q < 14'd16 || OW'(addr_q) >= brk_q;
	assign st.hdr_bad    = !rd[0] || csz == '0 || bp_q + OW'(csz) > brk_q;
	assign st.walk_stop  = hit || endw;
	assign st.found      = found_q;
	assign st.oom        = OW'(brk_q) + OW'(ext_c) > OW'(HEAP_BYTES);
	assign st.both_alloc = pal_q && rd[0];
	assign st.split      = fsize_q > asize32;
	assign st.clr_last   = clr_q == IW'(DEPTH - 1);

	always_comb begin
		rd_en   = 1'b0;
		rd_off  = '0;
		wr_en   = 1'b0;
		wr_off  = '0;
		wr_data = '0;
		unique case (cmd)
			CMD_CLEAR: begin
				wr_en   = 1'b1;
				wr_off  = {(OW-IW-2)'(0), clr_q, 2'b00};
				wr_data = init_val;
			end
			CMD_WALK_RD: begin
				rd_en  = 1'b1;
				rd_off = bp_q - OW'(4);
			end
			CMD_WALK: begin
				rd_en  = 1'b1;
				rd_off = nxt - OW'(4);
			end
			CMD_BEST_RD: begin
				rd_en  = 1'b1;
				rd_off = best_q - OW'(4);
			end
			CMD_LAST_RD: begin
				rd_en  = 1'b1;
				rd_off = last_q - OW'(4);
			end
			CMD_GROW_H: begin
				wr_en   = 1'b1;
				wr_off  = brk_q - OW'(4);
				wr_data = TW'(ext_q);
			end
			CMD_GROW_F: begin
				wr_en   = 1'b1;
				wr_off  = bp_q + OW'(sz_q) - OW'(8);
				wr_data = sz_q;
			end
			CMD_GROW_E: begin
				wr_en   = 1'b1;
				wr_off  = bp_q + OW'(sz_q) - OW'(4);
				wr_data = TW'(1);
			end
			CMD_FREE_RD: begin
				rd_en  = 1'b1;
				rd_off = OW'(addr_q) - OW'(4);
			end
			CMD_FREE_HDR: begin
				wr_en   = 1'b1;
				wr_off  = bp_q - OW'(4);
				wr_data = csz;
			end
			CMD_FREE_FTR: begin
				wr_en   = 1'b1;
				wr_off  = bp_q + OW'(sz_q) - OW'(8);
				wr_data = sz_q;
			end
			CMD_M_PF: begin
				rd_en  = 1'b1;
				rd_off = bp_q - OW'(8);
			end
			CMD_M_PH: begin
				rd_en  = 1'b1;
				rd_off = bp_q - OW'(csz) - OW'(4);
			end
			CMD_M_NH: begin
				rd_en  = 1'b1;
				rd_off = bp_q + OW'(sz_q) - OW'(4);
			end
			CMD_M_WH: begin
				wr_en   = 1'b1;
				wr_off  = bp_q - OW'(4);
				wr_data = total_q;
			end
			CMD_M_WF: begin
				wr_en   = 1'b1;
				wr_off  = bp_q + OW'(total_q) - OW'(8);
				wr_data = total_q;
			end
			CMD_CARVE_RD: begin
				rd_en  = 1'b1;
				rd_off = bp_q - OW'(4);
			end
			CMD_CARVE_H: begin
				wr_en   = 1'b1;
				wr_off  = bp_q - OW'(4);
				wr_data = asize32 | TW'(1);
			end
			CMD_CARVE_F: begin
				wr_en   = 1'b1;
				wr_off  = bp_q + OW'(asize32) - OW'(8);
				wr_data = asize32 | TW'(1);
			end
			CMD_CARVE_RH: begin
				wr_en   = 1'b1;
				wr_off  = bp_q + OW'(asize32) - OW'(4);
				wr_data = rest;
			end
			CMD_CARVE_RF: begin
				wr_en   = 1'b1;
				wr_off  = bp_q + OW'(fsize_q) - OW'(8);
				wr_data = rest;
			end
			default: begin
			end
		endcase
	end

	assign rd_ok = rd_off[OW-1:2] < (OW-2)'(DEPTH);
	assign wr_ok = wr_off[OW-1:2] < (OW-2)'(DEPTH);

	// reads outside the store answer a used block of size zero
	always_ff @(posedge clk) begin
		if (wr_en && wr_ok)
			mem[wr_off[IW+1:2]] <= wr_data;
		if (rd_en) begin
			rd_oob_q <= !rd_ok;
			if (rd_ok)
				rd_q <= mem[rd_off[IW+1:2]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			brk_q <= OW'(16 + CHUNK);
		end else begin
			if (cmd == CMD_CLEAR && clr_q != IW'(DEPTH - 1))
				clr_q <= clr_q + IW'(1);
			if (cmd == CMD_GROW_E)
				brk_q <= bp_q + OW'(sz_q);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				op_q       <= in_op;
				req_q      <= in_request_bytes;
				addr_q     <= in_block_address;
				asize_q    <= (in_request_bytes <= 15'd8) ? 16'd16 : {r16[15:3], 3'b000};
				bp_q       <= OW'(8);
				last_q     <= OW'(8);
				found_q    <= 1'b0;
				res_addr_q <= '0;
				status_q   <= (!in_op && in_request_bytes == '0) ? ST_ZERO : ST_OK;
			end
			CMD_WALK: begin
				if (hit || upd) begin
					best_q   <= bp_q;
					bestsz_q <= csz;
					found_q  <= 1'b1;
				end
				if (!hit && !endw) begin
					last_q <= bp_q;
					bp_q   <= nxt;
				end
			end
			CMD_BEST_RD: begin
				bp_q       <= best_q;
				res_addr_q <= best_q[13:0];
			end
			CMD_EXT: begin
				ext_q <= ext_c;
				if (st.oom)
					status_q <= ST_OOM;
			end
			CMD_GROW_H: begin
				bp_q <= brk_q;
				sz_q <= TW'(ext_q);
			end
			CMD_FREE_RD: bp_q <= OW'(addr_q);
			CMD_FREE_HDR: sz_q <= csz;
			CMD_M_PH: begin
				psz_q <= csz;
				pbp_q <= bp_q - OW'(csz);
			end
			CMD_M_NH: pal_q <= rd[0];
			CMD_M_SUM: begin
				total_q <= sz_q + (rd[0] ? '0 : csz) + (pal_q ? '0 : psz_q);
				if (!pal_q)
					bp_q <= pbp_q;
			end
			CMD_CARVE_RD: res_addr_q <= bp_q[13:0];
			CMD_CARVE_H: fsize_q <= csz;
			CMD_PUSH: begin
				out_addr_q   <= res_addr_q;
				out_status_q <= status_q;
			end
			default: begin
			end
		endcase
	end

	assign out_payload_address = out_addr_q;
	assign out_status          = out_status_q;

endmodule

// ===== hdl/btalloc_ctrl.sv =====
// ----------------------------------------------------------------------------
// btalloc_ctrl
// Sequencer for allocate, free, merge, grow and split; owns the handshakes.
// ----------------------------------------------------------------------------
module btalloc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	input  btalloc_pkg::dp_status_t st,
	output btalloc_pkg::dp_cmd_t    cmd
);
	import btalloc_pkg::*;

	state_t state_q, state_d;
	logic   m_valid_q;
	logic   push;
	logic   out_free;

	assign out_free = !m_valid_q || m_tready;
	assign push     = cmd == CMD_PUSH;
	assign m_tvalid = m_valid_q;
	assign s_tready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_CLR: begin
				cmd = CMD_CLEAR;
				if (st.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd     = CMD_ACCEPT;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (st.op) begin
					if (st.free_bad)
						state_d = S_OUT;
					else begin
						cmd     = CMD_FREE_RD;
						state_d = S_F_HDR;
					end
				end else if (st.zero_req)
					state_d = S_OUT;
				else begin
					cmd     = CMD_WALK_RD;
					state_d = S_WALK;
				end
			end
			// one block tag per cycle
			S_WALK: begin
				cmd = CMD_WALK;
				if (st.walk_stop)
					state_d = S_W_END;
			end
			S_W_END: begin
				if (st.found) begin
					cmd     = CMD_BEST_RD;
					state_d = S_C_H;
				end else begin
					cmd     = CMD_LAST_RD;
					state_d = S_EXT;
				end
			end
			S_EXT: begin
				cmd     = CMD_EXT;
				state_d = st.oom ? S_OUT : S_G_H;
			end
			S_G_H: begin
				cmd     = CMD_GROW_H;
				state_d = S_G_F;
			end
			S_G_F: begin
				cmd     = CMD_GROW_F;
				state_d = S_G_E;
			end
			S_G_E: begin
				cmd     = CMD_GROW_E;
				state_d = S_M_PF;
			end
			S_F_HDR: begin
				if (st.hdr_bad)
					state_d = S_OUT;
				else begin
					cmd     = CMD_FREE_HDR;
					state_d = S_F_FTR;
				end
			end
			S_F_FTR: begin
				cmd     = CMD_FREE_FTR;
				state_d = S_M_PF;
			end
			S_M_PF: begin
				cmd     = CMD_M_PF;
				state_d = S_M_PH;
			end
			S_M_PH: begin
				cmd     = CMD_M_PH;
				state_d = S_M_NH;
			end
			S_M_NH: begin
				cmd     = CMD_M_NH;
				state_d = S_M_SUM;
			end
			S_M_SUM: begin
				cmd = CMD_M_SUM;
				if (st.both_alloc)
					state_d = st.op ? S_OUT : S_C_RD;
				else
					state_d = S_M_WH;
			end
			S_M_WH: begin
				cmd     = CMD_M_WH;
				state_d = S_M_WF;
			end
			S_M_WF: begin
				cmd     = CMD_M_WF;
				state_d = st.op ? S_OUT : S_C_RD;
			end
			S_C_RD: begin
				cmd     = CMD_CARVE_RD;
				state_d = S_C_H;
			end
			S_C_H: begin
				cmd     = CMD_CARVE_H;
				state_d = S_C_F;
			end
			S_C_F: begin
				cmd     = CMD_CARVE_F;
				state_d = st.split ? S_C_RH : S_OUT;
			end
			S_C_RH: begin
				cmd     = CMD_CARVE_RH;
				state_d = S_C_RF;
			end
			S_C_RF: begin
				cmd     = CMD_CARVE_RF;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd     = CMD_PUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hdl/boundary_tag_best_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_best_fit_allocator
// Best-fit heap allocator with header/footer boundary tags.
// ----------------------------------------------------------------------------
// Allocate: block tags are walked in address order (one tag read
//   per cycle on the single memory read port); the heap grows when no free block fits.
// Free: includes the neighbor merge; rejected items are answered without it.
//   One item at a time; a result held at the output stalls the next one.
// Reset: a clearing pass writes every heap word and lays out prologue,
//   initial free block and epilogue.
module boundary_tag_best_fit_allocator #(
	parameter int HEAP_BYTES       = btalloc_pkg::HEAP_BYTES_DEF,
	parameter int INIT_CHUNK_BYTES = btalloc_pkg::INIT_CHUNK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [14:0] request_bytes, [28:15] block_address
	input  logic        s_tuser,  // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [13:0] payload_address
	output logic [1:0]  m_tuser   // [1:0] status
);
	import btalloc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;
	logic [13:0] payload_address;

	btalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	btalloc_dp #(
		.HEAP_BYTES       (HEAP_BYTES),
		.INIT_CHUNK_BYTES (INIT_CHUNK_BYTES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.in_op               (s_tuser),
		.in_request_bytes    (s_tdata[14:0]),
		.in_block_address    (s_tdata[28:15]),
		.st                  (st),
		.out_payload_address (payload_address),
		.out_status          (m_tuser)
	);

	assign m_tdata = {2'b00, payload_address};

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the boundary-tag best-fit allocator. Allocate and
// free items are streamed in with random gaps; a behavioral heap model
// predicts payload address and status for each item, and the monitor compares
// every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import btalloc_pkg::*;

	localparam int HEAP = 16384;
	localparam int WORDS = HEAP / 4;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [14:0] req;
		logic [13:0] addr;
	} req_item_t;

	typedef struct packed {
		logic [13:0] payload;
		logic [1:0]  status;
	} grant_t;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [31:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	boundary_tag_best_fit_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// heap mirror
	logic [31:0] heap_words [WORDS];
	longint      brk;
	req_item_t   pending_items [$];
	grant_t      expected_grants [$];
	logic [13:0] live_blocks [$];
	int          errors = 0;
	bit          stall_start = 0;
	logic        stall_sink = 1'b0;

	function automatic logic [31:0] tag_rd(longint off);
		if (off < 0 || (off >> 2) >= WORDS) return 32'd1;
		return heap_words[off >> 2];
	endfunction

	function automatic void tag_wr(longint off, logic [31:0] v);
		if (off >= 0 && (off >> 2) < WORDS) heap_words[off >> 2] = v;
	endfunction

	function automatic longint blk_sz(longint bp);
		return tag_rd(bp - 4) & SIZE_MASK;
	endfunction

	function automatic longint coalesce(longint bp);
		longint sz, psz, pbp, nsz, total;
		logic pal, nal;
		logic [31:0] nh, ph;
		sz = blk_sz(bp);
		psz = tag_rd(bp - 8) & SIZE_MASK;
		pbp = bp - psz;
		ph = tag_rd(pbp - 4);
		pal = ph[0];
		nh = tag_rd(bp + sz - 4);
		nal = nh[0];
		nsz = nh & SIZE_MASK;
		total = sz;
		if (pal && nal) return bp;
		if (!nal) total += nsz;
		if (!pal) begin
			total += psz;
			bp = pbp;
		end
		tag_wr(bp - 4, total);
		tag_wr(bp + total - 8, total);
		return bp;
	endfunction

	function automatic void split_block(longint bp, longint asize);
		longint fsize;
		fsize = blk_sz(bp);
		tag_wr(bp - 4, asize | 1);
		tag_wr(bp + asize - 8, asize | 1);
		if (fsize > asize) begin
			tag_wr(bp + asize - 4, fsize - asize);
			tag_wr(bp + fsize - 8, fsize - asize);
		end
	endfunction

	function automatic longint grow_heap(longint size);
		longint nb;
		nb = brk;
		tag_wr(nb - 4, size);
		tag_wr(nb + size - 8, size);
		tag_wr(nb + size - 4, 1);
		brk = nb + size;
		return coalesce(nb);
	endfunction

	function automatic void heap_reset();
		foreach (heap_words[i]) heap_words[i] = 0;
		heap_words[1] = 9;
		heap_words[2] = 9;
		heap_words[3] = 1;
		brk = 16;
		void'(grow_heap(256));
	endfunction

	function automatic grant_t heap_apply(req_item_t it);
		grant_t g;
		longint a, sz, asize, bp, best, bestsz, last, ext, lsz;
		logic [31:0] h;
		g = '0;
		if (it.op == OP_FREE) begin
			a = it.addr;
			if (a[2:0] != 0 || a < 16 || a >= brk) return g;
			h = tag_rd(a - 4);
			sz = h & SIZE_MASK;
			if (!h[0] || sz == 0 || a + sz > brk) return g;
			tag_wr(a - 4, sz);
			tag_wr(a + sz - 8, sz);
			void'(coalesce(a));
			return g;
		end
		if (it.req == 0) begin
			g.status = ST_ZERO;
			return g;
		end
		asize = (it.req <= 8) ? 16 : (longint'(it.req) + 15) / 8 * 8;
		bp = 8; best = 0; bestsz = -1; last = 8;
		while (bp >= 4 && bp - 4 < brk) begin
			h = tag_rd(bp - 4);
			sz = h & SIZE_MASK;
			if (!h[0] && sz == asize) begin
				best = bp;
				bestsz = sz;
				break;
			end
			if (!h[0] && asize < sz && (bestsz < 0 || sz < bestsz)) begin
				best = bp;
				bestsz = sz;
			end
			if (sz == 0 || bp + sz > brk) break;
			last = bp;
			bp += sz;
		end
		if (bestsz >= 0) begin
			split_block(best, asize);
			g.payload = best[13:0];
			return g;
		end
		h = tag_rd(last - 4);
		lsz = h & SIZE_MASK;
		ext = (!h[0] && lsz < asize) ? asize - lsz : asize;
		if (brk + ext > HEAP) begin
			g.status = ST_OOM;
			return g;
		end
		bp = grow_heap(ext);
		split_block(bp, asize);
		g.payload = bp[13:0];
		return g;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("boundary_tag_best_fit_allocator: mismatch");
		$finish;
	end

	// long receiver stall, counted here so the monitor only sees the flag
	initial begin
		wait (stall_start);
		@(posedge clk);
		stall_sink <= 1'b1;
		repeat (300) @(posedge clk);
		stall_sink <= 1'b0;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// driver: prediction happens on acceptance, so live_blocks tracks the model
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
			s_tuser  <= 0;
		end else begin
			req_item_t it;
			grant_t g;
			if (s_tvalid && s_tready) begin
				it = pending_items.pop_front();
				g = heap_apply(it);
				expected_grants.push_back(g);
				if (it.op == OP_ALLOC && g.status == ST_OK) live_blocks.push_back(g.payload);
				src_gap = pick_gap();
			end
			if ((!s_tvalid || s_tready) || !s_tvalid) begin
				if (pending_items.size() > (s_tvalid && s_tready ? 0 : 0) && src_gap == 0
				    && !(s_tvalid && !s_tready)) begin
					it = pending_items[0];
					s_tvalid <= 1;
					s_tdata  <= {3'b0, it.addr, it.req};
					s_tuser  <= it.op;
				end else if (!(s_tvalid && !s_tready)) begin
					s_tvalid <= 0;
					if (src_gap > 0) src_gap--;
				end
			end
		end
	end

	// monitor
	int sink_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			grant_t g;
			if (m_tvalid && m_tready) begin
				if (expected_grants.size() == 0) begin
					$error("unexpected result payload=%0d status=%0d", m_tdata[13:0], m_tuser);
					errors++;
				end else begin
					g = expected_grants.pop_front();
					if (m_tdata[13:0] !== g.payload) begin
						$error("payload_address expected %0d got %0d", g.payload, m_tdata[13:0]);
						errors++;
					end
					if (m_tuser !== g.status) begin
						$error("status expected %0d got %0d", g.status, m_tuser);
						errors++;
					end
				end
				sink_gap = pick_gap();
			end
			if (stall_sink) begin
				m_tready <= 0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	function automatic req_item_t mk(logic op, int req, int addr);
		req_item_t it;
		it.op = op;
		it.req = req[14:0];
		it.addr = addr[13:0];
		return it;
	endfunction

	// random bytes: mostly small, sometimes big enough to exercise growth
	function automatic int rand_req();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 0;
		if (r < 60) return $urandom_range(1, 64);
		if (r < 90) return $urandom_range(65, 600);
		if (r < 97) return $urandom_range(601, 3000);
		return $urandom_range(3001, 32767);
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_grants.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int k, idx;
		heap_reset();
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: zero size, minimum, exact fit, bad frees, double free, OOM, extremes
		pending_items.push_back(mk(OP_ALLOC, 0, 16383));
		pending_items.push_back(mk(OP_ALLOC, 1, 0));
		pending_items.push_back(mk(OP_ALLOC, 8, 0));
		pending_items.push_back(mk(OP_ALLOC, 9, 0));
		pending_items.push_back(mk(OP_ALLOC, 200, 0));
		pending_items.push_back(mk(OP_FREE, 0, 16));
		pending_items.push_back(mk(OP_FREE, 0, 16));
		pending_items.push_back(mk(OP_FREE, 0, 20));
		pending_items.push_back(mk(OP_FREE, 0, 8));
		pending_items.push_back(mk(OP_FREE, 0, 0));
		pending_items.push_back(mk(OP_FREE, 32767, 16383));
		pending_items.push_back(mk(OP_FREE, 0, 32));
		pending_items.push_back(mk(OP_ALLOC, 24, 0));
		pending_items.push_back(mk(OP_ALLOC, 16384, 0));
		pending_items.push_back(mk(OP_ALLOC, 32767, 16383));
		pending_items.push_back(mk(OP_ALLOC, 5000, 0));
		pending_items.push_back(mk(OP_ALLOC, 9000, 0));
		pending_items.push_back(mk(OP_FREE, 0, 48));
		pending_items.push_back(mk(OP_ALLOC, 10000, 0));
		wait_drained();

		// sender pause until drained, then a long receiver hold-off under load
		stall_start = 1;
		for (k = 0; k < 20; k++) pending_items.push_back(mk(OP_ALLOC, $urandom_range(1, 40), 0));

		for (k = 0; k < 560; k++) begin
			while (pending_items.size() > 4) @(posedge clk);
			if (k % 150 == 149) begin
				// free everything that is live so the heap refills
				wait_drained();
				while (live_blocks.size() != 0)
					pending_items.push_back(mk(OP_FREE, $urandom, live_blocks.pop_front()));
				continue;
			end
			idx = $urandom_range(0, 99);
			if (idx < 50) begin
				pending_items.push_back(mk(OP_ALLOC, rand_req(), $urandom));
			end else if (idx < 88 && live_blocks.size() != 0) begin
				idx = $urandom_range(0, live_blocks.size() - 1);
				pending_items.push_back(mk(OP_FREE, $urandom, live_blocks[idx]));
				live_blocks.delete(idx);
			end else begin
				pending_items.push_back(mk(OP_FREE, $urandom, $urandom));
			end
		end
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("boundary_tag_best_fit_allocator: match");
		else
			$display("boundary_tag_best_fit_allocator: mismatch");
		$finish;
	end
endmodule
